// File: hw/rtl/dca_pkg.sv
// Shared types, constants and the answer record table of the DNS captive answer builder.
`default_nettype none

package dca_pkg;

    // Default for the largest accepted query length in bytes.
    localparam int MAX_QUERY_DEF = 512;

    // Register indexes of the configuration port.
    typedef enum logic [0:0] {
        REG_ANSWER_ADDRESS = 1'b0,
        REG_ANSWER_TTL     = 1'b1
    } t_cfg_index;

    localparam logic [31:0] ANSWER_ADDRESS_RST = 32'hC0A8_0401;
    localparam logic [31:0] ANSWER_TTL_RST     = 32'd60;

    // DNS header layout.
    localparam int          HDR_LEN        = 12;
    localparam int          NAME_START     = 12;
    localparam int          MIN_QUERY      = 17;
    localparam int          QTAIL_LEN      = 5;  // zero byte + type + class
    localparam logic [3:0]  POS_FLAGS_HI   = 4'd2;
    localparam logic [3:0]  POS_FLAGS_LO   = 4'd3;
    localparam logic [3:0]  POS_QDCOUNT_HI = 4'd4;
    localparam logic [3:0]  POS_QDCOUNT_LO = 4'd5;
    localparam logic [3:0]  POS_ANCOUNT_HI = 4'd6;
    localparam logic [3:0]  POS_ANCOUNT_LO = 4'd7;
    localparam logic [3:0]  POS_NSCOUNT_HI = 4'd8;
    localparam logic [3:0]  POS_NSCOUNT_LO = 4'd9;
    localparam logic [3:0]  POS_ARCOUNT_HI = 4'd10;
    localparam logic [3:0]  POS_ARCOUNT_LO = 4'd11;
    localparam logic [7:0]  REPLY_FLAGS_HI = 8'h84;
    localparam logic [7:0]  LABEL_PTR_MASK = 8'hC0;
    localparam logic [15:0] ONE_QUESTION   = 16'd1;

    // Answer record: pointer to offset 12, type A, class IN, TTL, length 4, address.
    localparam int          ANSWER_LEN     = 16;
    localparam logic [7:0]  NAME_PTR_HI    = 8'hC0;
    localparam logic [7:0]  NAME_PTR_LO    = 8'h0C;
    localparam logic [15:0] RR_TYPE_A      = 16'd1;
    localparam logic [15:0] RR_CLASS_IN    = 16'd1;
    localparam logic [15:0] RR_RDLENGTH    = 16'd4;

    // One parsed query byte handed from the parser to the reply sequencer.
    typedef struct packed {
        logic       valid;
        logic       fwd;    // byte belongs to the forwarded header or question
        logic       last;   // final byte of the query
        logic       bad;    // query judged bad (meaningful with last)
        logic [7:0] ob;     // forwarded byte after header rewrite
    } t_event;

    function automatic logic [7:0] answer_byte(input logic [3:0]  idx,
                                               input logic [31:0] ttl,
                                               input logic [31:0] addr);
        logic [7:0] b;
        case (idx)
            4'd0:    b = NAME_PTR_HI;
            4'd1:    b = NAME_PTR_LO;
            4'd2:    b = RR_TYPE_A[15:8];
            4'd3:    b = RR_TYPE_A[7:0];
            4'd4:    b = RR_CLASS_IN[15:8];
            4'd5:    b = RR_CLASS_IN[7:0];
            4'd6:    b = ttl[31:24];
            4'd7:    b = ttl[23:16];
            4'd8:    b = ttl[15:8];
            4'd9:    b = ttl[7:0];
            4'd10:   b = RR_RDLENGTH[15:8];
            4'd11:   b = RR_RDLENGTH[7:0];
            4'd12:   b = addr[31:24];
            4'd13:   b = addr[23:16];
            4'd14:   b = addr[15:8];
            default: b = addr[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dca_query_if.sv
// Query byte channel: one item per query byte with a last-byte flag.
`default_nettype none

interface dca_query_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dca_reply_if.sv
// Reply byte channel: one item per reply byte with frame end and drop marks.
`default_nettype none

interface dca_reply_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       drop;

    modport source (output valid, output out_byte, output frame_end, output drop, input ready);
    modport sink   (input valid, input out_byte, input frame_end, input drop, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dca_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none

interface dca_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dns_captive_answer_builder.sv
// Top level of the DNS captive answer builder: parser, reply sequencer and registers.
//
//  Channel   Dir  Handshake     Item
//  i_query   in   valid/ready   data_byte[7:0], last_byte
//  o_reply   out  valid/ready   out_byte[7:0], frame_end, drop
//  i_cfg     in   valid/ready   index (0 address, 1 TTL), data[31:0]
//
// Each query byte is registered in the parser's event register and then in the output
// register, so bytes stream through at one item per cycle while o_reply does not stall.
// A good query's last byte expands into up to 17 reply items; the reply sequencer
// emits them in order, and the query input waits until the sequencer loads the last
// of them into the output register.
// A stall on o_reply holds the output register and backs up into i_query through the
// single event register between parser and sequencer.
// Reset is synchronous and active low; it clears parser state, the event and output valid
// bits and loads the register defaults 192.168.4.1 and a TTL of 60 seconds.
`default_nettype none

module dns_captive_answer_builder #(
    parameter int MAX_QUERY = dca_pkg::MAX_QUERY_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dca_query_if.sink    i_query,
    dca_reply_if.source  o_reply,
    dca_cfg_if.sink      i_cfg
);

    // Config registers. The user must write only while idle; the block does not check.
    logic [31:0] r_answer_address;
    logic [31:0] r_answer_ttl;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_answer_address <= dca_pkg::ANSWER_ADDRESS_RST;
            r_answer_ttl     <= dca_pkg::ANSWER_TTL_RST;
        end else if (i_cfg.valid) begin
            case (dca_pkg::t_cfg_index'(i_cfg.index))
                dca_pkg::REG_ANSWER_ADDRESS: r_answer_address <= i_cfg.data;
                dca_pkg::REG_ANSWER_TTL:     r_answer_ttl     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // The parser registers one event per accepted query byte.
    dca_pkg::t_event ev;
    logic            in_take;
    logic            ev_done;

    dca_parse #(
        .MAX_QUERY (MAX_QUERY)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (in_take),
        .i_data_byte (i_query.data_byte),
        .i_last_byte (i_query.last_byte),
        .i_ev_done   (ev_done),
        .o_ev        (ev)
    );

    // Reply sequencer. r_k counts items already sent for the held event. On a good final
    // byte the forwarded byte (if any) goes first, then the 16 answer bytes follow.
    logic [4:0] r_k;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       r_out_drop;

    logic       out_free;
    logic       need_out;
    logic       emit_ob;
    logic [3:0] ans_idx;
    logic       item_last;
    logic       emit;
    logic [7:0] item_byte;
    logic       item_end;
    logic       item_drop;
    logic [4:0] k_minus;

    always_comb begin
        out_free  = !r_out_valid || o_reply.ready;
        need_out  = ev.fwd || ev.last;
        emit_ob   = ev.fwd && (r_k == 5'd0);
        k_minus   = r_k - {4'd0, ev.fwd};
        ans_idx   = k_minus[3:0];
        item_byte = ev.ob;
        item_end  = 1'b0;
        item_drop = 1'b0;
        item_last = 1'b1;

        if (ev.last) begin
            if (ev.bad) begin
                // A bad query closes with a single drop item and nothing forwarded.
                item_byte = 8'd0;
                item_end  = 1'b1;
                item_drop = 1'b1;
            end else if (emit_ob) begin
                item_last = 1'b0;
            end else begin
                item_byte = dca_pkg::answer_byte(ans_idx, r_answer_ttl, r_answer_address);
                item_last = (ans_idx == 4'(dca_pkg::ANSWER_LEN - 1));
                item_end  = item_last;
            end
        end

        emit    = ev.valid && need_out && out_free;
        ev_done = ev.valid && (!need_out || (out_free && item_last));
    end

    assign i_query.ready = !ev.valid || ev_done;
    assign in_take       = i_query.valid && i_query.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ev_done) begin
                r_k <= '0;
            end else if (emit) begin
                r_k <= r_k + 5'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_reply.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= item_byte;
            r_out_end  <= item_end;
            r_out_drop <= item_drop;
        end
    end

    assign o_reply.valid     = r_out_valid;
    assign o_reply.out_byte  = r_out_byte;
    assign o_reply.frame_end = r_out_end;
    assign o_reply.drop      = r_out_drop;

    // The item counter only runs through a good final byte's answer.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= 5'(dca_pkg::ANSWER_LEN))
        else $error("reply item counter out of range");

    a_k_context: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != 5'd0) |-> (ev.valid && ev.last && !ev.bad))
        else $error("item counter running outside a good final byte");

    a_drop_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_drop) |-> (r_out_end && (r_out_byte == 8'd0)))
        else $error("drop item is not a zero closing item");

    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> ev.valid)
        else $error("accepted query byte left no event");

endmodule

`default_nettype wire

// File: hw/rtl/dca_parse.sv
// Query parser: header rewrite, label walk and query checks, one byte per cycle.
`default_nettype none

module dca_parse #(
    parameter int MAX_QUERY = dca_pkg::MAX_QUERY_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,      // query byte accepted this cycle
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    input  wire logic            i_ev_done,   // sequencer finished the held event
    output dca_pkg::t_event      o_ev
);

    // Positions reach MAX_QUERY plus a label jump of up to 64.
    localparam int LW = $clog2(MAX_QUERY + 65);

    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_next_label, n_next_label;
    logic          r_closed, n_closed;
    logic [LW-1:0] r_reply_end, n_reply_end;
    logic          r_bad, n_bad;
    logic [7:0]    r_count_high, n_count_high;
    logic          r_ev_valid;
    logic          r_ev_fwd, r_ev_last, r_ev_bad;
    logic [7:0]    r_ev_ob;

    logic          fwd;
    logic [7:0]    ob;
    logic [LW-1:0] len;
    logic          bad_final;

    always_comb begin
        n_pos        = r_pos;
        n_next_label = r_next_label;
        n_closed     = r_closed;
        n_reply_end  = r_reply_end;
        n_bad        = r_bad;
        n_count_high = r_count_high;
        fwd          = 1'b0;
        ob           = i_data_byte;

        if (r_pos >= LW'(MAX_QUERY)) begin
            n_bad = 1'b1;
        end else if (r_pos < LW'(dca_pkg::HDR_LEN)) begin
            fwd = 1'b1;
            case (r_pos[3:0])
                dca_pkg::POS_FLAGS_HI: begin
                    if (i_data_byte[7]) begin
                        n_bad = 1'b1;
                    end
                    ob = dca_pkg::REPLY_FLAGS_HI;
                end
                dca_pkg::POS_FLAGS_LO:   ob = 8'd0;
                dca_pkg::POS_QDCOUNT_HI: n_count_high = i_data_byte;
                dca_pkg::POS_QDCOUNT_LO: begin
                    if ({r_count_high, i_data_byte} != dca_pkg::ONE_QUESTION) begin
                        n_bad = 1'b1;
                    end
                end
                dca_pkg::POS_ANCOUNT_HI: ob = 8'd0;
                dca_pkg::POS_ANCOUNT_LO: ob = 8'd1;
                dca_pkg::POS_NSCOUNT_HI,
                dca_pkg::POS_NSCOUNT_LO,
                dca_pkg::POS_ARCOUNT_HI,
                dca_pkg::POS_ARCOUNT_LO: ob = 8'd0;
                default: ;
            endcase
        end else if (!r_closed) begin
            fwd = 1'b1;
            if (r_pos == r_next_label) begin
                if (i_data_byte == 8'd0) begin
                    n_closed    = 1'b1;
                    n_reply_end = r_pos + LW'(dca_pkg::QTAIL_LEN);
                end else if ((i_data_byte & dca_pkg::LABEL_PTR_MASK) != 8'd0) begin
                    n_bad = 1'b1;
                end else begin
                    n_next_label = r_pos + LW'(i_data_byte[5:0]) + LW'(1);
                end
            end
        end else if (r_pos < r_reply_end) begin
            fwd = 1'b1;
        end

        if (r_pos < LW'(MAX_QUERY)) begin
            n_pos = r_pos + LW'(1);
        end

        // Length check on the final byte uses the state after this byte.
        len       = r_pos + LW'(1);
        bad_final = n_bad || (len < LW'(dca_pkg::MIN_QUERY)) || (len > LW'(MAX_QUERY))
                    || !n_closed || (n_reply_end > len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_next_label <= LW'(dca_pkg::NAME_START);
            r_closed     <= 1'b0;
            r_reply_end  <= '0;
            r_bad        <= 1'b0;
            r_count_high <= '0;
            r_ev_valid   <= 1'b0;
        end else begin
            if (i_take) begin
                if (i_last_byte) begin
                    r_pos        <= '0;
                    r_next_label <= LW'(dca_pkg::NAME_START);
                    r_closed     <= 1'b0;
                    r_reply_end  <= '0;
                    r_bad        <= 1'b0;
                    r_count_high <= '0;
                end else begin
                    r_pos        <= n_pos;
                    r_next_label <= n_next_label;
                    r_closed     <= n_closed;
                    r_reply_end  <= n_reply_end;
                    r_bad        <= n_bad;
                    r_count_high <= n_count_high;
                end
                r_ev_valid <= 1'b1;
            end else if (i_ev_done) begin
                r_ev_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_ev_fwd  <= fwd;
            r_ev_last <= i_last_byte;
            r_ev_bad  <= bad_final;
            r_ev_ob   <= ob;
        end
    end

    assign o_ev = '{valid: r_ev_valid, fwd: r_ev_fwd, last: r_ev_last,
                    bad: r_ev_bad, ob: r_ev_ob};

endmodule

`default_nettype wire

// File: sim/dns_captive_answer_builder_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the DNS captive answer builder, driven by query frames.
module dns_captive_answer_builder_test;

    // The block is built with its default query limit, and the predictor follows that.
    localparam int QUERY_LIMIT     = dca_pkg::MAX_QUERY_DEF;
    // A byte passes the event register and then the output register; this is plenty to settle.
    localparam int DRAIN_CYCLES    = 8;
    // The watchdog ends the run after this many cycles in a row without any handshake.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 55;

    // These are the frame shapes the stimulus can build. As the directed table builds them,
    // every kind except the good, full and noise ones breaks one rule, so the block must
    // close the frame with a drop.
    typedef enum {
        FK_GOOD,      // well-formed query, with optional trailing bytes
        FK_FULL,      // well-formed query padded to exactly the query limit
        FK_LONG,      // well-formed query padded past the query limit
        FK_SHORT,     // fewer than 17 bytes
        FK_RESPONSE,  // flags byte says this is a response
        FK_QDCOUNT,   // question count other than one
        FK_POINTER,   // label length byte with a top bit set
        FK_UNCLOSED,  // last label runs past the end of the frame
        FK_TRUNC,     // name closed but type or class cut off
        FK_NOISE      // random bytes of random length
    } t_frame_kind;

    typedef struct packed {
        logic [7:0] ob;
        logic       fe;
        logic       dr;
    } t_reply_byte;

    typedef struct {
        t_frame_kind kind;
        int unsigned labels;
        int unsigned label_len;  // zero picks a random length per label
        int unsigned extra;      // trailing bytes after the question
        bit          typed;      // closing items are written into the table
    } t_frame_row;

    // This is the directed part. Rows marked typed carry their closing items in
    // typed_close: a drop mark for each broken rule, and for the very first frame the
    // answer record with the register defaults. All other rows use the predictor.
    t_frame_row directed_rows [10] = '{
        '{FK_GOOD,     0, 0,  0, 1'b1},  // root name: the shortest legal query
        '{FK_SHORT,    1, 3,  0, 1'b1},
        '{FK_RESPONSE, 1, 3,  0, 1'b1},
        '{FK_QDCOUNT,  1, 3,  0, 1'b1},
        '{FK_POINTER,  2, 3,  0, 1'b1},
        '{FK_UNCLOSED, 1, 3,  0, 1'b1},
        '{FK_TRUNC,    1, 3,  0, 1'b1},
        '{FK_GOOD,     1, 63, 2, 1'b0},  // longest label, then trailing bytes
        '{FK_LONG,     1, 3,  0, 1'b1},
        '{FK_FULL,     3, 2,  0, 1'b0}   // exactly at the query limit
    };

    logic clk;
    logic rst_n;

    dca_query_if q_if ();
    dca_reply_if r_if ();
    dca_cfg_if   c_if ();

    dns_captive_answer_builder u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_query (q_if),
        .o_reply (r_if),
        .i_cfg   (c_if)
    );

    // This is the predictor's copy of the parser state and of the two registers.
    int unsigned at_byte;
    int unsigned label_pos;
    int unsigned tail_end;
    bit          name_seen;
    bit          frame_bad;
    logic [7:0]  qd_hi;
    logic [31:0] cfg_addr;
    logic [31:0] cfg_ttl;

    t_reply_byte step_replies [$];  // results caused by the query byte just accepted
    t_reply_byte typed_close  [$];  // closing items typed in by the directed table
    t_reply_byte reply_due_q  [$];  // replies that the block still has to deliver
    logic [7:0]  query_bytes  [$];  // the frame being sent

    int  errors = 0;
    bit  steady_flow = 1'b0;  // when set, neither side inserts gaps

    function automatic void clear_frame_state();
        at_byte   = 0;
        label_pos = dca_pkg::NAME_START;
        tail_end  = 0;
        name_seen = 1'b0;
        frame_bad = 1'b0;
        qd_hi     = 8'h00;
    endfunction

    function automatic void add_reply(logic [7:0] b, logic fe, logic dr);
        step_replies.push_back('{b, fe, dr});
    endfunction

    // This computes the reply items that one accepted query byte causes, and it
    // advances the parser state in the same way the block does.
    function automatic void build_reply_bytes(logic [7:0] d, logic l);
        int unsigned i;
        bit          fwd;
        logic [7:0]  ob;
        i   = at_byte;
        fwd = 1'b0;
        ob  = d;
        step_replies.delete();
        if (i >= QUERY_LIMIT) begin
            // Bytes past the limit are neither parsed nor forwarded.
            frame_bad = 1'b1;
        end else if (i < dca_pkg::HDR_LEN) begin
            fwd = 1'b1;
            case (i[3:0])
                dca_pkg::POS_FLAGS_HI: begin
                    if (d[7]) frame_bad = 1'b1;
                    ob = dca_pkg::REPLY_FLAGS_HI;
                end
                dca_pkg::POS_FLAGS_LO, dca_pkg::POS_ANCOUNT_HI,
                dca_pkg::POS_NSCOUNT_HI, dca_pkg::POS_NSCOUNT_LO,
                dca_pkg::POS_ARCOUNT_HI, dca_pkg::POS_ARCOUNT_LO: ob = 8'h00;
                dca_pkg::POS_ANCOUNT_LO: ob = 8'h01;
                dca_pkg::POS_QDCOUNT_HI: qd_hi = d;
                dca_pkg::POS_QDCOUNT_LO: begin
                    if ({qd_hi, d} != dca_pkg::ONE_QUESTION) frame_bad = 1'b1;
                end
                default: ;
            endcase
        end else if (!name_seen) begin
            // Walk the name one label at a time. Only length bytes are examined.
            fwd = 1'b1;
            if (i == label_pos) begin
                if (d == 8'h00) begin
                    name_seen = 1'b1;
                    tail_end  = i + dca_pkg::QTAIL_LEN;
                end else if ((d & 8'hC0) != 8'h00) begin
                    frame_bad = 1'b1;
                end else begin
                    label_pos = i + d + 1;
                end
            end
        end else if (i < tail_end) begin
            fwd = 1'b1;
        end

        if (at_byte < QUERY_LIMIT) at_byte++;

        if (!l) begin
            if (fwd) add_reply(ob, 1'b0, 1'b0);
            return;
        end

        if (i + 1 < dca_pkg::MIN_QUERY || i + 1 > QUERY_LIMIT || !name_seen ||
            tail_end > i + 1)
            frame_bad = 1'b1;

        if (frame_bad) begin
            add_reply(8'h00, 1'b1, 1'b1);
        end else begin
            if (fwd) add_reply(ob, 1'b0, 1'b0);
            // The answer record is a pointer to offset 12, type A, class IN, the TTL,
            // a length of 4, and then the address.
            add_reply(8'hC0, 1'b0, 1'b0);
            add_reply(8'h0C, 1'b0, 1'b0);
            add_reply(8'h00, 1'b0, 1'b0);
            add_reply(8'h01, 1'b0, 1'b0);
            add_reply(8'h00, 1'b0, 1'b0);
            add_reply(8'h01, 1'b0, 1'b0);
            for (int k = 3; k >= 0; k--) add_reply(cfg_ttl[8*k +: 8], 1'b0, 1'b0);
            add_reply(8'h00, 1'b0, 1'b0);
            add_reply(8'h04, 1'b0, 1'b0);
            for (int k = 3; k >= 0; k--) add_reply(cfg_addr[8*k +: 8], k == 0, 1'b0);
        end
        clear_frame_state();
    endfunction

    // Most gaps are short and only a few are long.
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // This builds one query frame of the given kind into query_bytes.
    function automatic void make_query(t_frame_kind kind, int unsigned labels,
                                       int unsigned label_len, int unsigned extra);
        logic [7:0]  flags;
        logic [15:0] qd;
        int unsigned n;
        int unsigned target;
        query_bytes.delete();
        if (kind == FK_NOISE) begin
            n = $urandom_range(1, 40);
            repeat (n) query_bytes.push_back(8'($urandom));
            return;
        end
        query_bytes.push_back(8'($urandom));
        query_bytes.push_back(8'($urandom));
        flags    = 8'($urandom);
        flags[7] = (kind == FK_RESPONSE);
        query_bytes.push_back(flags);
        query_bytes.push_back(8'($urandom));
        qd = dca_pkg::ONE_QUESTION;
        if (kind == FK_QDCOUNT) begin
            do qd = 16'($urandom); while (qd == dca_pkg::ONE_QUESTION);
        end
        query_bytes.push_back(qd[15:8]);
        query_bytes.push_back(qd[7:0]);
        // The answer, authority and additional counts are rewritten, so their values do not matter.
        repeat (6) query_bytes.push_back(8'($urandom));
        for (int unsigned lab = 0; lab < labels; lab++) begin
            n = (label_len != 0) ? label_len : $urandom_range(1, 8);
            if (kind == FK_POINTER && lab == labels - 1) begin
                query_bytes.push_back(8'($urandom_range(8'h40, 8'hFF)));
                query_bytes.push_back(8'($urandom));
            end else if (kind == FK_UNCLOSED && lab == labels - 1) begin
                // The label claims 63 bytes, but the frame ends after only 4 to 40 of them.
                if (n < 4) n = 4;
                if (n > 40) n = 40;
                query_bytes.push_back(8'd63);
                repeat (n) query_bytes.push_back(8'($urandom));
                return;
            end else begin
                query_bytes.push_back(8'(n));
                repeat (n) query_bytes.push_back(8'($urandom));
            end
        end
        query_bytes.push_back(8'h00);
        repeat (4) query_bytes.push_back(8'($urandom));
        if (kind == FK_TRUNC) begin
            n = $urandom_range(1, 4);
            repeat (n) void'(query_bytes.pop_back());
        end
        repeat (extra) query_bytes.push_back(8'($urandom));
        if (kind == FK_SHORT) begin
            target = $urandom_range(1, dca_pkg::MIN_QUERY - 1);
            while (query_bytes.size() > target) void'(query_bytes.pop_back());
        end
        if (kind == FK_FULL || kind == FK_LONG) begin
            target = (kind == FK_FULL) ? QUERY_LIMIT : QUERY_LIMIT + $urandom_range(1, 4);
            while (query_bytes.size() < target) query_bytes.push_back(8'($urandom));
        end
    endfunction

    // This sends one query byte and queues the replies it causes. The task is entered
    // and left at a falling edge.
    task automatic send_byte(logic [7:0] d, logic l);
        int gap;
        int keep;
        gap = pick_gap();
        if (gap != 0) begin
            q_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        q_if.data_byte = d;
        q_if.last_byte = l;
        q_if.valid     = 1'b1;
        do @(posedge clk); while (!q_if.ready);
        build_reply_bytes(d, l);
        keep = step_replies.size();
        if (l && typed_close.size() != 0) begin
            keep = step_replies.size() - typed_close.size();
            if (keep < 0) keep = 0;
        end
        for (int k = 0; k < keep; k++) reply_due_q.push_back(step_replies[k]);
        if (l) begin
            foreach (typed_close[k]) reply_due_q.push_back(typed_close[k]);
            typed_close.delete();
        end
        @(negedge clk);
    endtask

    task automatic send_query();
        foreach (query_bytes[k]) send_byte(query_bytes[k], k == query_bytes.size() - 1);
    endtask

    // The sender holds off until every queued reply has come out and the pipeline is empty.
    task automatic wait_idle();
        q_if.valid = 1'b0;
        while (reply_due_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(dca_pkg::t_cfg_index idx, logic [31:0] v);
        c_if.index = idx;
        c_if.data  = v;
        c_if.valid = 1'b1;
        do @(posedge clk); while (!c_if.ready);
        if (idx == dca_pkg::REG_ANSWER_ADDRESS) cfg_addr = v;
        else cfg_ttl = v;
        @(negedge clk);
        c_if.valid = 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The reply side runs stretches of ready and stalls of mostly short, sometimes long, length.
    initial begin
        int hold;
        bit hold_val;
        int r;
        hold       = 0;
        hold_val   = 1'b0;
        r_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                r = $urandom_range(0, 99);
                if (steady_flow || r < 55) begin
                    hold_val = 1'b1;
                    hold     = steady_flow ? 1 : $urandom_range(1, 12);
                end else if (r < 92) begin
                    hold_val = 1'b0;
                    hold     = $urandom_range(1, 3);
                end else begin
                    hold_val = 1'b0;
                    hold     = $urandom_range(10, 40);
                end
            end
            r_if.ready = hold_val;
            hold--;
        end
    end

    // Each reply item is compared with the oldest one still due. The byte carries no
    // meaning on a drop mark, so it is not compared there.
    always @(posedge clk) begin
        t_reply_byte want;
        if (rst_n && r_if.valid && r_if.ready) begin
            if (reply_due_q.size() == 0) begin
                $display("%0t: unexpected reply item byte %h end %b drop %b", $time,
                         r_if.out_byte, r_if.frame_end, r_if.drop);
                errors++;
            end else begin
                want = reply_due_q.pop_front();
                if (r_if.frame_end !== want.fe || r_if.drop !== want.dr ||
                    (!want.dr && r_if.out_byte !== want.ob)) begin
                    $display("%0t: expected byte %h end %b drop %b, got %h end %b drop %b",
                             $time, want.ob, want.fe, want.dr,
                             r_if.out_byte, r_if.frame_end, r_if.drop);
                    errors++;
                end
            end
        end
    end

    // The watchdog counts cycles in a row without a handshake on any channel.
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (q_if.valid && q_if.ready) || (r_if.valid && r_if.ready) ||
                (c_if.valid && c_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: watchdog expired with %0d replies still due", $time, reply_due_q.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int unsigned phase_items;
        int          r;
        t_frame_kind kind;
        q_if.valid     = 1'b0;
        q_if.data_byte = 8'h00;
        q_if.last_byte = 1'b0;
        c_if.valid     = 1'b0;
        c_if.index     = dca_pkg::REG_ANSWER_ADDRESS;
        c_if.data      = 32'h0;
        rst_n          = 1'b0;
        cfg_addr       = 32'hC0A8_0401;
        cfg_ttl        = 32'd60;
        clear_frame_state();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The directed frames run with the register defaults still in place.
        foreach (directed_rows[k]) begin
            make_query(directed_rows[k].kind, directed_rows[k].labels,
                       directed_rows[k].label_len, directed_rows[k].extra);
            if (directed_rows[k].typed) begin
                if (directed_rows[k].kind == FK_GOOD) begin
                    // The answer for 192.168.4.1 with a TTL of 60 seconds.
                    typed_close = '{'{8'hC0, 1'b0, 1'b0}, '{8'h0C, 1'b0, 1'b0},
                                    '{8'h00, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
                                    '{8'h00, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
                                    '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
                                    '{8'h00, 1'b0, 1'b0}, '{8'h3C, 1'b0, 1'b0},
                                    '{8'h00, 1'b0, 1'b0}, '{8'h04, 1'b0, 1'b0},
                                    '{8'hC0, 1'b0, 1'b0}, '{8'hA8, 1'b0, 1'b0},
                                    '{8'h04, 1'b0, 1'b0}, '{8'h01, 1'b1, 1'b0}};
                end else begin
                    typed_close = '{'{8'h00, 1'b1, 1'b1}};
                end
            end
            send_query();
        end

        // The random phases each start from an idle block with new register values: all zeros,
        // then all ones, then random values with no gaps on either side, then a random TTL.
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(dca_pkg::REG_ANSWER_ADDRESS, 32'h0000_0000);
                    write_reg(dca_pkg::REG_ANSWER_TTL, 32'h0000_0000);
                end
                1: begin
                    write_reg(dca_pkg::REG_ANSWER_TTL, 32'hFFFF_FFFF);
                    write_reg(dca_pkg::REG_ANSWER_ADDRESS, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(dca_pkg::REG_ANSWER_ADDRESS, $urandom);
                    write_reg(dca_pkg::REG_ANSWER_TTL, $urandom);
                    steady_flow = 1'b1;
                end
                default: write_reg(dca_pkg::REG_ANSWER_TTL, $urandom);
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                // Most frames are well formed with random content. The rest break one rule
                // or are plain noise.
                r = $urandom_range(0, 99);
                if (r < 65) kind = FK_GOOD;
                else if (r < 70) kind = FK_SHORT;
                else if (r < 75) kind = FK_RESPONSE;
                else if (r < 80) kind = FK_QDCOUNT;
                else if (r < 85) kind = FK_POINTER;
                else if (r < 90) kind = FK_UNCLOSED;
                else if (r < 95) kind = FK_TRUNC;
                else kind = FK_NOISE;
                make_query(kind, $urandom_range(1, 3),
                           ($urandom_range(0, 19) == 0) ? 63 : 0,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
                send_query();
                phase_items += query_bytes.size();
            end
            steady_flow = 1'b0;
        end

        q_if.valid = 1'b0;
        while (reply_due_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
